@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off during reset.
`define OTSU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define OTSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define OTSU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/otsu_pkg.sv @@
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared types and fixed field widths of the Otsu threshold finder.
// ----------------------------------------------------------------------------
package otsu_pkg;

	localparam int PIXEL_W = 8;
	localparam int THR_W   = 8;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_PIX,
		ST_DRAIN,
		ST_SCAN_RD,
		ST_SCAN_ACC,
		ST_CHECK,
		ST_MUL_A,
		ST_MUL_B,
		ST_MUL_D2,
		ST_MUL_P,
		ST_MUL_L,
		ST_MUL_R,
		ST_EMIT
	} otsu_state_t;

endpackage

@@ rtl/core/otsu_pix_if.sv @@
// ----------------------------------------------------------------------------
// otsu_pix_if
// Pixel stream channel: gray level plus end-of-image flag.
// ----------------------------------------------------------------------------
interface otsu_pix_if;
	import otsu_pkg::*;

	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] pixel;
	logic               last;

	modport source (output valid, pixel, last, input ready);
	modport sink   (input valid, pixel, last, output ready);
endinterface

@@ rtl/core/otsu_thr_if.sv @@
// ----------------------------------------------------------------------------
// otsu_thr_if
// Result channel: one threshold per image.
// ----------------------------------------------------------------------------
interface otsu_thr_if;
	import otsu_pkg::*;

	logic             valid;
	logic             ready;
	logic [THR_W-1:0] threshold;

	modport source (output valid, threshold, input ready);
	modport sink   (input valid, threshold, output ready);
endinterface

@@ rtl/core/otsu_threshold_finder.sv @@
// ----------------------------------------------------------------------------
// otsu_threshold_finder
// Histograms a gray pixel stream and, after the last pixel, finds the Otsu
// threshold by exact integer comparison of between-class variances.
// ----------------------------------------------------------------------------
//  channel   dir   payload            beat
//  pixels    in    pixel[7:0], last   one gray pixel
//  result    out   threshold[7:0]     one per image, after the last pixel
//
//  Pixels: one beat per cycle while in the pixel state, histogram kept in
//  a one-port-read RAM with read-modify-write and forwarding from the last
//  write. Scan: per gray level the states SCAN_RD, SCAN_ACC and CHECK, plus,
//  for a split with both classes non-empty, 6 shift-add multiplies at one
//  multiplier bit per cycle.
//  Reset: a clearing pass writes every bin to zero, no pixel taken meanwhile.
//  The scan clears each bin as it reads it; result stalls hold the scan end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module otsu_threshold_finder #(
	parameter int MAX_PIXELS_LOG2 = 20,
	parameter int GRAY_LEVELS     = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	otsu_pix_if.sink          pixels,
	otsu_thr_if.source        result
);
	import otsu_pkg::*;

	localparam int CW = MAX_PIXELS_LOG2 + 1;
	localparam int GB = $clog2(GRAY_LEVELS);
	localparam int NW = CW + GB;
	localparam int SW = CW + 2 * GB;
	localparam int PW = SW + NW;
	localparam int XW = 2 * PW + 2 * NW;
	localparam logic [GB-1:0] T_LAST    = GB'(GRAY_LEVELS - 1);
	localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

	otsu_state_t state_q, state_d;

	logic [CW-1:0] mem [GRAY_LEVELS];
	logic [CW-1:0] rd_q;
	logic          mem_we;
	logic [GB-1:0] mem_wa, mem_ra;
	logic [CW-1:0] mem_wd;

	logic [GB-1:0] t_q;
	logic [GB-1:0] px_s1;
	logic          vld_s1;
	logic [GB-1:0] lw_addr_q;
	logic [CW-1:0] lw_data_q;
	logic          lw_vld_q;
	logic [CW-1:0] cur;
	logic [CW-1:0] cur_inc;

	logic [NW-1:0] n_all_q, n0_q, n1;
	logic [SW-1:0] s_all_q, s0_q, s1;
	logic [GB+CW-1:0] bin_wsum;

	logic [XW-1:0] a_q, acc_q, mul_a_in;
	logic [PW-1:0] b_q, mul_b_in;
	logic          mul_load, mul_done;

	logic [PW-1:0]   prod_a_q, prod_b, diff;
	logic [2*PW-1:0] d2_q, best_d2_q;
	logic [2*NW-1:0] p_q, best_p_q;
	logic [XW-1:0]   lhs_q;
	logic [GB-1:0]   best_t_q;

	logic               out_vld_q;
	logic [THR_W-1:0]   thr_q;
	logic               in_ready;
	logic [GB+PIXEL_W-1:0] px_ext;
	logic [GB-1:0]      px_idx;
	logic [GB+THR_W-1:0] thr_ext;
	logic               accept;

	// Pixel index with clamp to the top bin.
	assign px_ext = {{GB{1'b0}}, pixels.pixel};
	assign px_idx = (px_ext >= (GB+PIXEL_W)'(GRAY_LEVELS)) ? T_LAST : px_ext[GB-1:0];
	assign thr_ext = {{THR_W{1'b0}}, best_t_q};

	assign pixels.ready     = in_ready;
	assign accept           = pixels.valid && in_ready;
	assign result.valid     = out_vld_q;
	assign result.threshold = thr_q;

	// Forward the last write; the RAM read is issued in the accept cycle.
	assign cur     = (lw_vld_q && lw_addr_q == px_s1) ? lw_data_q : rd_q;
	assign cur_inc = (cur == COUNT_MAX) ? cur : cur + CW'(1);

	assign n1       = n_all_q - n0_q;
	assign s1       = s_all_q - s0_q;
	assign bin_wsum = t_q * rd_q;
	assign mul_done = (b_q == '0);
	assign prod_b   = acc_q[PW-1:0];
	assign diff     = (prod_a_q >= prod_b) ? prod_a_q - prod_b : prod_b - prod_a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		mem_we   = 1'b0;
		mem_wa   = t_q;
		mem_wd   = '0;
		mem_ra   = t_q;
		mul_load = 1'b0;
		mul_a_in = '0;
		mul_b_in = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (t_q == T_LAST) state_d = ST_PIX;
			end
			ST_PIX: begin
				in_ready = 1'b1;
				if (vld_s1) begin
					mem_we = 1'b1;
					mem_wa = px_s1;
					mem_wd = cur_inc;
				end
				if (pixels.valid) begin
					mem_ra = px_idx;
					if (pixels.last) state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				mem_we  = vld_s1;
				mem_wa  = px_s1;
				mem_wd  = cur_inc;
				state_d = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_ACC;
			end
			ST_SCAN_ACC: begin
				mem_we  = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (n0_q == '0 || n1 == '0) begin
					state_d = (t_q == T_LAST) ? ST_EMIT : ST_SCAN_RD;
				end else begin
					mul_load = 1'b1;
					mul_a_in = XW'(s0_q);
					mul_b_in = PW'(n1);
					state_d  = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				if (mul_done) begin
					mul_load = 1'b1;
					mul_a_in = XW'(s1);
					mul_b_in = PW'(n0_q);
					state_d  = ST_MUL_B;
				end
			end
			ST_MUL_B: begin
				if (mul_done) begin
					mul_load = 1'b1;
					mul_a_in = XW'(diff);
					mul_b_in = diff;
					state_d  = ST_MUL_D2;
				end
			end
			ST_MUL_D2: begin
				if (mul_done) begin
					mul_load = 1'b1;
					mul_a_in = XW'(n0_q);
					mul_b_in = PW'(n1);
					state_d  = ST_MUL_P;
				end
			end
			ST_MUL_P: begin
				if (mul_done) begin
					mul_load = 1'b1;
					mul_a_in = XW'(d2_q);
					mul_b_in = PW'(best_p_q);
					state_d  = ST_MUL_L;
				end
			end
			ST_MUL_L: begin
				if (mul_done) begin
					mul_load = 1'b1;
					mul_a_in = XW'(best_d2_q);
					mul_b_in = PW'(p_q);
					state_d  = ST_MUL_R;
				end
			end
			ST_MUL_R: begin
				if (mul_done) state_d = (t_q == T_LAST) ? ST_EMIT : ST_SCAN_RD;
			end
			ST_EMIT: begin
				if (!out_vld_q) state_d = ST_PIX;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// Histogram RAM, read-first.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q       <= '0;
			vld_s1    <= 1'b0;
			lw_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
			n_all_q   <= '0;
			s_all_q   <= '0;
			n0_q      <= '0;
			s0_q      <= '0;
			best_d2_q <= '0;
			best_p_q  <= (2*NW)'(1);
			best_t_q  <= '0;
		end else begin
			vld_s1 <= accept;
			if (mem_we) begin
				lw_vld_q <= 1'b1;
			end

			if (vld_s1 && cur != COUNT_MAX) begin
				n_all_q <= n_all_q + NW'(1);
				s_all_q <= s_all_q + SW'(px_s1);
			end

			if (state_q == ST_CLEAR || state_q == ST_DRAIN) begin
				t_q <= (state_q == ST_CLEAR && t_q != T_LAST) ? t_q + GB'(1) : '0;
			end else if ((state_q == ST_CHECK || state_q == ST_MUL_R)
					&& state_d == ST_SCAN_RD) begin
				t_q <= t_q + GB'(1);
			end

			if (state_q == ST_SCAN_ACC) begin
				n0_q <= n0_q + NW'(rd_q);
				s0_q <= s0_q + SW'(bin_wsum);
			end

			if (state_q == ST_MUL_R && mul_done && lhs_q > acc_q) begin
				best_d2_q <= d2_q;
				best_p_q  <= p_q;
				best_t_q  <= t_q;
			end

			if (state_q == ST_EMIT && !out_vld_q) begin
				out_vld_q <= 1'b1;
				n_all_q   <= '0;
				s_all_q   <= '0;
				n0_q      <= '0;
				s0_q      <= '0;
				best_d2_q <= '0;
				best_p_q  <= (2*NW)'(1);
				best_t_q  <= '0;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) px_s1 <= px_idx;
		if (mem_we) begin
			lw_addr_q <= mem_wa;
			lw_data_q <= mem_wd;
		end
		if (state_q == ST_EMIT && !out_vld_q) thr_q <= thr_ext[THR_W-1:0];

		// Shift-add multiplier, one multiplier bit per cycle.
		if (mul_load) begin
			a_q   <= mul_a_in;
			b_q   <= mul_b_in;
			acc_q <= '0;
		end else if (!mul_done) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end

		if (state_q == ST_MUL_A && mul_done) prod_a_q <= acc_q[PW-1:0];
		if (state_q == ST_MUL_D2 && mul_done) d2_q <= acc_q[2*PW-1:0];
		if (state_q == ST_MUL_P && mul_done) p_q <= acc_q[2*NW-1:0];
		if (state_q == ST_MUL_L && mul_done) lhs_q <= acc_q;
	end

	`OTSU_ASSERT_NXT(a_last_drain, clk, arst_n, accept && pixels.last, state_q == ST_DRAIN, "last beat did not start drain")
	`OTSU_ASSERT_IMP(a_scan_quiet, clk, arst_n, state_q == ST_SCAN_RD, !vld_s1, "pixel write pending at scan")
	`OTSU_ASSERT(a_n0_bound, clk, arst_n, n0_q <= n_all_q, "class 0 count above total")
	`OTSU_ASSERT_IMP(a_emit_src, clk, arst_n, $rose(out_vld_q), $past(state_q == ST_EMIT), "result without scan end")

endmodule

@@ tb/tb_otsu_threshold_finder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_otsu_threshold_finder
// Streams gray images with random gaps into the threshold finder, predicts
// each threshold from an exact integer histogram search and checks every
// result beat in order, with random and long stalls on the result side.
// ----------------------------------------------------------------------------
module tb_otsu_threshold_finder;
	import otsu_pkg::*;

	localparam int GRAY      = 256;
	localparam int BIN_MAX   = (1 << 21) - 1;
	localparam int CYC_LIMIT = 8000000;
	localparam int HOLD_CYC  = 40000;

	class thr_scoreboard;
		int unsigned           hist[GRAY];
		logic [THR_W-1:0]      thr_q[$];
		int                    errors;
		int                    n_pixels;
		int                    n_images;
		int                    n_checked;

		function new();
			foreach (hist[i]) hist[i] = 0;
			errors = 0; n_pixels = 0; n_images = 0; n_checked = 0;
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			errors++;
		endtask

		// exact between-class variance search, cross-multiplied
		function logic [THR_W-1:0] otsu_pick();
			logic [63:0]  n_all, s_all, n0, s0, n1, s1;
			logic [191:0] a, b, d, d2, p, lhs, rhs, best_d2, best_p;
			logic [THR_W-1:0] best_t;
			n_all = 0; s_all = 0; n0 = 0; s0 = 0;
			for (int t = 0; t < GRAY; t++) begin
				n_all += hist[t];
				s_all += 64'(t) * hist[t];
			end
			best_d2 = 0; best_p = 1; best_t = 0;
			for (int t = 0; t < GRAY; t++) begin
				n0 += hist[t];
				s0 += 64'(t) * hist[t];
				n1 = n_all - n0;
				s1 = s_all - s0;
				if (n0 != 0 && n1 != 0) begin
					a = 192'(s0) * 192'(n1);
					b = 192'(s1) * 192'(n0);
					d = (a >= b) ? a - b : b - a;
					d2 = d * d;
					p = 192'(n0) * 192'(n1);
					lhs = d2 * best_p;
					rhs = best_d2 * p;
					if (lhs > rhs) begin
						best_d2 = d2; best_p = p; best_t = THR_W'(t);
					end
				end
			end
			return best_t;
		endfunction

		function void note_pixel(logic [PIXEL_W-1:0] px, logic lst);
			n_pixels++;
			if (hist[px] < BIN_MAX) hist[px]++;
			if (lst) begin
				thr_q.push_back(otsu_pick());
				foreach (hist[i]) hist[i] = 0;
				n_images++;
			end
		endfunction

		task check_result(logic [THR_W-1:0] thr);
			logic [THR_W-1:0] exp_thr;
			n_checked++;
			if (thr_q.size() == 0) begin
				report($sformatf("unexpected threshold %0d", thr));
			end else begin
				exp_thr = thr_q.pop_front();
				if (thr !== exp_thr)
					report($sformatf("threshold %0d, expected %0d", thr, exp_thr));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	longint cycles;
	bit stim_done;
	thr_scoreboard sb;

	otsu_pix_if pix();
	otsu_thr_if res();

	otsu_threshold_finder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix.sink),
		.result (res.source)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYC_LIMIT) begin
				$display("Timeout after %0d cycles", cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// mostly short gaps, some long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_pixel(logic [PIXEL_W-1:0] px, logic lst, bit gaps);
		bit acc;
		int n;
		pix.valid <= 1'b1;
		pix.pixel <= px;
		pix.last  <= lst;
		do begin
			@(negedge clk);
			acc = pix.ready;
			@(posedge clk);
		end while (!acc);
		sb.note_pixel(px, lst);
		n = gaps ? gap_len() : 0;
		if (n > 0) begin
			pix.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// image of len pixels drawn from [lo, hi]
	task automatic send_image(int len, int lo, int hi, bit gaps);
		for (int i = 0; i < len; i++)
			send_pixel(PIXEL_W'($urandom_range(lo, hi)), i == len - 1, gaps);
	endtask

	// result side: random stalls, one long hold-off after a few images
	initial begin
		int n;
		bit fire;
		bit held;
		held = 1'b0;
		res.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held && sb.n_checked >= 5) begin
				held = 1'b1;
				res.ready <= 1'b0;
				for (int c = 0; c < HOLD_CYC; c++) @(posedge clk);
			end
			n = gap_len();
			if (n > 0) begin
				res.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			res.ready <= 1'b1;
			do begin
				@(negedge clk);
				fire = res.valid && res.ready;
				if (fire) sb.check_result(res.threshold);
				if (!fire) @(posedge clk);
			end while (!fire);
		end
	end

	initial begin
		int len, lo, hi, span;
		sb = new();
		stim_done = 1'b0;
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.pixel = '0;
		pix.last  = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: lone pixel, one gray level, extremes, two levels, ramp
		send_pixel(8'd0, 1'b1, 1'b0);
		send_pixel(8'd255, 1'b0, 1'b0);
		send_pixel(8'd255, 1'b0, 1'b0);
		send_pixel(8'd255, 1'b1, 1'b0);
		send_pixel(8'd0, 1'b0, 1'b1);
		send_pixel(8'd255, 1'b1, 1'b1);
		send_pixel(8'd85, 1'b0, 1'b0);
		send_pixel(8'd170, 1'b0, 1'b0);
		send_pixel(8'd170, 1'b1, 1'b0);
		for (int i = 0; i < 8; i++)
			send_pixel(PIXEL_W'(i * 36 + 3), i == 7, 1'b0);

		// random images, mostly narrow gray ranges to keep the scan short
		while (sb.n_pixels < 650) begin
			len = $urandom_range(1, 30);
			if ($urandom_range(0, 9) == 0) begin
				lo = 0; hi = 255;
			end else begin
				span = $urandom_range(0, 15);
				lo = $urandom_range(0, 255 - span);
				hi = lo + span;
			end
			send_image(len, lo, hi, $urandom_range(0, 3) != 0);
		end
		pix.valid <= 1'b0;
		stim_done = 1'b1;

		while (sb.thr_q.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (sb.thr_q.size() != 0)
			sb.report($sformatf("%0d thresholds never arrived", sb.thr_q.size()));

		$display("Ran %0d pixels in %0d images, %0d thresholds checked, %0d cycles",
			sb.n_pixels, sb.n_images, sb.n_checked, cycles);
		$display("Covered lone-pixel, single-level, extreme and full-range images");
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
